FILE: src/fctab_pkg.sv
package fctab_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_EOC   = 2'd2,
		OP_ALLOC = 2'd3
	} op_t;

	localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;
	localparam logic [15:0] ENTRY_FREE   = 16'h0000;
	localparam logic [16:0] FIRST_DATA   = 17'd2;
	localparam logic [12:0] SIZE_RESET   = 13'd4096;

	// controller -> datapath
	typedef struct packed {
		logic clr_en;
		logic accept;
		logic scan_start;
		logic scan_run;
		logic rd_load;
		logic res_load;
		logic imm_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;
		logic rd_ok;
		logic scan_done;
	} sts_t;

endpackage

FILE: src/fctab_ctrl.sv
module fctab_ctrl import fctab_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output cmd_t       cmd,
	input  sts_t       sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;
	op_t    op;

	assign op       = op_t'(in_op);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.clr_en     = (state_q == ST_CLEAR);
		cmd.accept     = accept;
		cmd.scan_start = accept && (op == OP_ALLOC);
		cmd.imm_load   = accept && (op == OP_WRITE || op == OP_EOC ||
			(op == OP_READ && !sts.rd_ok));
		cmd.scan_run   = (state_q == ST_SCAN);
		cmd.rd_load    = (state_q == ST_READ) && out_free;
		cmd.res_load   = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.imm_load || cmd.rd_load || cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_done) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept && op == OP_ALLOC) begin
						state_q <= ST_SCAN;
					end else if (accept && op == OP_READ && sts.rd_ok) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (out_free) state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (sts.scan_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule

FILE: src/fctab_dpath.sv
module fctab_dpath import fctab_pkg::*; #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	input  logic [1:0]  in_op,
	input  logic [15:0] in_index,
	input  logic [15:0] in_link,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic [15:0] read_value,
	output logic [15:0] free_index,
	output logic        status
);

	localparam int          AW      = $clog2(TABLE_DEPTH);
	localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST  = AW'(TABLE_DEPTH - 1);

	logic [15:0]   mem [TABLE_DEPTH];
	logic [15:0]   rdata_q;

	logic [12:0]   cfg_q;
	logic [AW-1:0] clr_q;
	logic [15:0]   hint_q;
	logic [16:0]   addr_q;
	logic          phase_q;
	logic          pend_q;
	logic [16:0]   pend_addr_q;
	logic [15:0]   res_idx_q;
	logic          res_st_q;

	logic [16:0] size;
	logic [16:0] idx_w;
	logic [16:0] hint_p1;
	logic [16:0] stop;
	logic [16:0] lim;
	logic        inr;
	logic        hit;
	logic        wr_ok;
	logic        we;
	logic [AW-1:0] waddr;
	logic [15:0] wdata;
	logic        re;
	logic [AW-1:0] raddr;
	op_t         op;

	assign op      = op_t'(in_op);
	assign size    = ({4'd0, cfg_q} > DEPTH_W) ? DEPTH_W : {4'd0, cfg_q};
	assign idx_w   = {1'b0, in_index};
	assign hint_p1 = {1'b0, hint_q} + 17'd1;
	assign stop    = (hint_p1 > size) ? size : hint_p1;
	assign lim     = phase_q ? stop : size;
	assign inr     = addr_q < lim;
	assign hit     = pend_q && (rdata_q == ENTRY_FREE);
	assign wr_ok   = (idx_w >= FIRST_DATA) && (idx_w < size);

	assign sts.clr_done  = (clr_q == LAST);
	assign sts.rd_ok     = idx_w < size;
	assign sts.scan_done = hit || (!inr && phase_q);

	// single write port shared by the clearing pass and stores
	assign we    = cmd.clr_en ||
		(cmd.accept && (op == OP_WRITE || op == OP_EOC) && wr_ok);
	assign waddr = cmd.clr_en ? clr_q : in_index[AW-1:0];
	assign wdata = cmd.clr_en ? ENTRY_FREE : ((op == OP_WRITE) ? in_link : END_OF_CHAIN);

	assign re    = (cmd.accept && op == OP_READ) || (cmd.scan_run && !hit && inr);
	assign raddr = cmd.scan_run ? addr_q[AW-1:0] : in_index[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= SIZE_RESET;
			clr_q   <= '0;
			hint_q  <= FIRST_DATA[15:0];
			phase_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (cfg_we) cfg_q <= cfg_wdata;
			if (cmd.clr_en && !sts.clr_done) clr_q <= clr_q + AW'(1);
			if (cmd.scan_start) begin
				phase_q <= 1'b0;
				pend_q  <= 1'b0;
			end else if (cmd.scan_run) begin
				if (hit) begin
					hint_q <= pend_addr_q[15:0];
					pend_q <= 1'b0;
				end else if (inr) begin
					pend_q <= 1'b1;
				end else begin
					// first range exhausted: wrap to the first data entry
					pend_q  <= 1'b0;
					phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			addr_q <= {1'b0, hint_q};
		end else if (cmd.scan_run) begin
			if (hit) begin
				res_idx_q <= pend_addr_q[15:0];
				res_st_q  <= 1'b0;
			end else if (inr) begin
				pend_addr_q <= addr_q;
				addr_q      <= addr_q + 17'd1;
			end else if (!phase_q) begin
				addr_q <= FIRST_DATA;
			end else begin
				res_idx_q <= 16'd0;
				res_st_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.imm_load) begin
			read_value <= (op == OP_READ) ? END_OF_CHAIN : 16'd0;
			free_index <= 16'd0;
			status     <= (op == OP_READ) ? 1'b1 : !wr_ok;
		end else if (cmd.rd_load) begin
			read_value <= rdata_q;
			free_index <= 16'd0;
			status     <= 1'b0;
		end else if (cmd.res_load) begin
			read_value <= 16'd0;
			free_index <= res_idx_q;
			status     <= res_st_q;
		end
	end

endmodule

FILE: src/fat16_cluster_table_allocator.sv
// FAT16 cluster link table with next-fit free-cluster search.
//
// Requests arrive on the s_ side: s_tuser carries the operation (read, write,
// end of chain, allocate), s_tdata the cluster index and link value. Each
// request gives one response on the m_ side: read value and free index in
// m_tdata, status in m_tuser. The size in use is set through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, which the block does not enforce.
// A write, an end of chain and an out-of-range read have their response
// registered at accept, so m_tvalid rises in the cycle after; a read in range
// passes through the memory read register and then the output registers; an
// allocate reads one table entry per cycle through the single memory read port.
// One request is in flight at a time.
// After reset a clearing pass zeroes the table, one entry per cycle;
// s_tready stays low until it ends.
// A response held by m_tready low keeps s_tready low; the next request is
// accepted at the edge where the held response leaves.
module fat16_cluster_table_allocator import fctab_pkg::*; #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,   // table_entries_in_use
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // cluster_index[15:0], link_value[31:16]
	input  logic [1:0]  s_tuser,     // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // read_value[15:0], free_index[31:16]
	output logic        m_tuser      // status[0]
);

	cmd_t        cmd;
	sts_t        sts;
	logic [15:0] read_value;
	logic [15:0] free_index;

	fctab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	fctab_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_op      (s_tuser),
		.in_index   (s_tdata[15:0]),
		.in_link    (s_tdata[31:16]),
		.cmd        (cmd),
		.sts        (sts),
		.read_value (read_value),
		.free_index (free_index),
		.status     (m_tuser)
	);

	assign m_tdata = {free_index, read_value};

endmodule

FILE: verif/fat16_alloc_checker.sv
module fat16_alloc_checker import fctab_pkg::*; #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending,
	output int          resp_count,
	output int          miss_count,
	output logic [15:0] alloc_hint
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] rd_val;
		logic [15:0] found;
		logic        status;
	} link_resp_t;

	logic [15:0] link_mem [TABLE_DEPTH];
	logic [15:0] next_hint;
	logic [12:0] size_cfg;
	link_resp_t  answer_q [$];
	int          errors;
	int          answered;
	int          misses;

	function automatic int unsigned live_entries();
		return (size_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_cfg);
	endfunction

	// Apply one request to the shadow table and return the response it must give.
	function automatic link_resp_t predict_request(op_t op, logic [15:0] idx,
			logic [15:0] val);
		link_resp_t  r;
		int unsigned lim;
		int unsigned n;
		int unsigned stop;
		logic        hit;
		r = '0;
		lim = live_entries();
		hit = 1'b0;
		case (op)
			OP_READ: begin
				if (idx < lim) begin
					r.rd_val = link_mem[idx];
				end else begin
					r.rd_val = END_OF_CHAIN;
					r.status = 1'b1;
				end
			end
			OP_WRITE, OP_EOC: begin
				if (idx < FIRST_DATA || idx >= lim) begin
					r.status = 1'b1;
				end else begin
					link_mem[idx] = (op == OP_WRITE) ? val : END_OF_CHAIN;
				end
			end
			default: begin
				// next fit: hint to end, then wrap from the first data entry up to the hint
				for (n = next_hint; n < lim && !hit; n++) begin
					if (link_mem[n] == ENTRY_FREE) begin
						r.found = n[15:0];
						hit = 1'b1;
					end
				end
				stop = next_hint + 1;
				if (stop > lim) begin
					stop = lim;
				end
				for (n = FIRST_DATA; n < stop && !hit; n++) begin
					if (link_mem[n] == ENTRY_FREE) begin
						r.found = n[15:0];
						hit = 1'b1;
					end
				end
				if (hit) begin
					next_hint = r.found;
				end else begin
					r.status = 1'b1;
					misses++;
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		link_resp_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				link_mem[i] = ENTRY_FREE;
			end
			next_hint = FIRST_DATA[15:0];
			size_cfg = SIZE_RESET;
			answer_q.delete();
			errors = 0;
			answered = 0;
			misses = 0;
		end else begin
			if (cfg_we) begin
				size_cfg = cfg_wdata;
			end
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected response: expected none, got read %h free %h status %b",
						$time, m_tdata[15:0], m_tdata[31:16], m_tuser);
					errors++;
				end else begin
					want = answer_q.pop_front();
					answered++;
					check_field("read_value", want.rd_val, m_tdata[15:0]);
					check_field("free_index", want.found, m_tdata[31:16]);
					check_field("status", {15'd0, want.status}, {15'd0, m_tuser});
				end
			end
			if (s_tvalid && s_tready) begin
				answer_q.push_back(predict_request(op_t'(s_tuser), s_tdata[15:0], s_tdata[31:16]));
			end
		end
		fail_count <= errors;
		pending <= answer_q.size();
		resp_count <= answered;
		miss_count <= misses;
		alloc_hint <= next_hint;
	end

	final begin
		if (answer_q.size() != 0) begin
			$display("%0t: %0d responses still outstanding", $time, answer_q.size());
		end
	end

endmodule

FILE: verif/tb.sv
module tb;
	import fctab_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = 4096;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = TABLE_DEPTH + 100;
	localparam int LIMIT_CYCLES = 5000000;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [12:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;

	int          fail_count;
	int          pending;
	int          resp_count;
	int          miss_count;
	logic [15:0] alloc_hint;

	bit          no_gaps    = 1'b0;
	int          hold_asked = 0;
	int          op_seen [4] = '{0, 0, 0, 0};
	int          sizes_tried = 0;
	int unsigned cycle_cnt  = 0;

	fat16_cluster_table_allocator #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	fat16_alloc_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.pending   (pending),
		.resp_count(resp_count),
		.miss_count(miss_count),
		.alloc_hint(alloc_hint)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d responses outstanding",
				$time, cycle_cnt, pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [15:0] pick_index(int eff);
		logic [15:0] pick;
		int          r;
		r = $urandom_range(0, 99);
		pick = 16'($urandom);
		if (eff > 0 && r < 70) begin
			pick = 16'($urandom_range(0, eff - 1));
		end else if (eff > 0 && r < 85) begin
			case ($urandom_range(0, 5))
				0: pick = 16'd0;
				1: pick = 16'd1;
				2: pick = FIRST_DATA[15:0];
				3: pick = 16'(eff - 1);
				4: pick = 16'(eff);
				default: pick = 16'(eff + 1);
			endcase
		end
		return pick;
	endfunction

	function automatic logic [15:0] pick_link();
		logic [15:0] v;
		int          r;
		r = $urandom_range(0, 99);
		v = 16'($urandom);
		// zero frees an entry, so allocation keeps finding holes
		if (r < 25) begin
			v = ENTRY_FREE;
		end else if (r < 35) begin
			v = END_OF_CHAIN;
		end
		return v;
	endfunction

	task automatic send_req(op_t op, logic [15:0] idx, logic [15:0] val);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {val, idx};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		op_seen[int'(op)]++;
	endtask

	task automatic drain_responses();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_size(logic [12:0] v);
		drain_responses();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sizes_tried++;
	endtask

	// Mostly chain building: allocate, look, terminate the new cluster, link the old tail to it.
	task automatic run_phase(logic [12:0] size_val, int n_items, bit steady, bit with_hold);
		int          sent;
		int          eff;
		logic [15:0] tail;
		bit          linked;
		set_size(size_val);
		eff = (size_val > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_val);
		no_gaps = steady;
		if (with_hold) begin
			hold_asked <= hold_asked + 1;
		end
		sent = 0;
		linked = 1'b0;
		tail = '0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 65) begin
				send_req(OP_ALLOC, 16'($urandom), 16'($urandom));
				send_req(OP_READ, alloc_hint, 16'($urandom));
				send_req(OP_EOC, alloc_hint, 16'($urandom));
				sent += 3;
				if (linked) begin
					send_req(OP_WRITE, tail, alloc_hint);
					sent++;
				end
				tail = alloc_hint;
				linked = 1'b1;
			end else begin
				send_req(op_t'($urandom_range(0, 3)), pick_index(eff), pick_link());
				sent++;
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		int k;
		int r;
		int hold_done;
		hold_done = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_asked != hold_done) begin
				// hold the output long enough for the input side to back up
				hold_done++;
				m_tready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(40, 120)) @(posedge clk);
				end else if (r < 60) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end else if (r < 92) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat ($urandom_range(15, 50)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// full-size table straight out of reset
		send_req(OP_READ, 16'd0, 16'd0);
		send_req(OP_READ, 16'd4096, 16'd0);
		send_req(OP_READ, 16'hFFFF, 16'hFFFF);
		send_req(OP_WRITE, 16'd0, 16'h1234);
		send_req(OP_WRITE, 16'd1, 16'h4321);
		send_req(OP_WRITE, 16'd2, 16'h5A5A);
		send_req(OP_WRITE, 16'd4095, 16'hFFFF);
		send_req(OP_WRITE, 16'd4096, 16'h0001);
		send_req(OP_EOC, 16'd1, 16'd0);
		send_req(OP_EOC, 16'd3, 16'd0);
		send_req(OP_READ, 16'd4095, 16'd0);
		send_req(OP_ALLOC, 16'd0, 16'd0);
		send_req(OP_WRITE, 16'd2, ENTRY_FREE);

		// size register above the table depth clamps to the depth
		set_size(13'h1FFF);
		send_req(OP_READ, 16'd1, 16'd0);
		send_req(OP_READ, 16'd4096, 16'd0);
		send_req(OP_ALLOC, 16'd0, 16'd0);

		// empty volume: everything out of range, allocate finds nothing
		set_size(13'd0);
		send_req(OP_READ, 16'd0, 16'd0);
		send_req(OP_EOC, 16'd2, 16'd0);
		send_req(OP_ALLOC, 16'd0, 16'd0);

		// hint now sits beyond the size in use; one data entry only
		set_size(13'd3);
		send_req(OP_READ, 16'd2, 16'd0);
		send_req(OP_ALLOC, 16'd0, 16'd0);
		send_req(OP_EOC, 16'd2, 16'd0);
		send_req(OP_ALLOC, 16'd0, 16'd0);
		send_req(OP_READ, 16'd3, 16'd0);

		run_phase(13'd16, 30, 1'b0, 1'b1);
		run_phase(13'd40, 20, 1'b1, 1'b0);
		run_phase(13'd4096, 12, 1'b0, 1'b0);
		run_phase(13'h1FFF, 8, 1'b0, 1'b0);
		run_phase(13'd1, 6, 1'b0, 1'b0);
		run_phase(13'd2, 6, 1'b1, 1'b0);
		run_phase(13'($urandom_range(5, 300)), 15, 1'b0, 1'b0);
		run_phase(13'd0, 5, 1'b0, 1'b0);
		run_phase(13'd16, 8, 1'b0, 1'b0);

		drain_responses();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d reads, %0d writes, %0d end-of-chain marks, %0d allocates",
			op_seen[int'(OP_READ)], op_seen[int'(OP_WRITE)], op_seen[int'(OP_EOC)],
			op_seen[int'(OP_ALLOC)]);
		$display("Used %0d size settings; checked %0d responses; %0d allocates found the table full",
			sizes_tried, resp_count, miss_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/fctab_pkg.sv
src/fctab_ctrl.sv
src/fctab_dpath.sv
src/fat16_cluster_table_allocator.sv
verif/fat16_alloc_checker.sv
verif/tb.sv
